FILE: src/ris_pkg.sv
// Shared types and constants for the reference input selector.
// Used by the front, queue and back modules and by the top level.
package ris_pkg;

	localparam int QUEUE_DEPTH = 2;

	// Selection method codes.
	localparam logic [1:0] METHOD_MANUAL   = 2'd0;
	localparam logic [1:0] METHOD_PRIORITY = 2'd1;
	localparam logic [1:0] METHOD_SSM      = 2'd2;

	// Register indexes as decoded from paddr[2].
	localparam logic REG_SELECT_METHOD  = 1'b0;
	localparam logic REG_MANUAL_CHANNEL = 1'b1;

	localparam logic signed [3:0] NO_CHANNEL = -4'sd1;

	typedef struct packed {
		logic [1:0]        select_method;
		logic signed [3:0] manual_channel;
	} ris_cfg_t;

	// One classified status word as it travels from the front to the back.
	typedef struct packed {
		logic [2:0]  channel;
		logic        elig;
		logic        manual_hit;
		logic [15:0] priority_high;
		logic [15:0] priority_low;
		logic        last;
	} ris_item_t;

endpackage

FILE: src/ris_status_if.sv
// Channel carrying one reference status word per handshake.
// Depends on nothing.
interface ris_status_if;
	logic        valid;
	logic        ready;
	logic [2:0]  channel;
	logic        qualified;
	logic        wants_selection;
	logic [15:0] priority_high;
	logic [15:0] priority_low;
	logic        last;

	modport source (output valid, channel, qualified, wants_selection, priority_high,
		priority_low, last, input ready);
	modport sink (input valid, channel, qualified, wants_selection, priority_high,
		priority_low, last, output ready);
endinterface

FILE: src/ris_select_if.sv
// Channel carrying the selection result of one scan.
// Depends on nothing.
interface ris_select_if;
	logic              valid;
	logic              ready;
	logic signed [3:0] active_channel;
	logic              changed;

	modport source (output valid, active_channel, changed, input ready);
	modport sink (input valid, active_channel, changed, output ready);
endinterface

FILE: src/ris_front.sv
// Front stage: accepts status words, works out eligibility and the manual match.
// Depends on ris_pkg and ris_status_if.
module ris_front import ris_pkg::*; #(
	parameter int INPUT_COUNT = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	ris_status_if.sink        status,
	input  ris_cfg_t          cfg,
	output logic              item_valid,
	output ris_item_t         item,
	input  logic              item_ready
);

	logic      valid_s1;
	ris_item_t item_s1;
	logic      accept;
	logic      in_range;

	assign status.ready = !valid_s1 || item_ready;
	assign accept       = status.valid && status.ready;
	assign in_range     = 32'(status.channel) < INPUT_COUNT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (item_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.channel       <= status.channel;
			item_s1.elig          <= status.qualified && status.wants_selection && in_range;
			item_s1.manual_hit    <= !cfg.manual_channel[3] &&
				(cfg.manual_channel[2:0] == status.channel);
			item_s1.priority_high <= status.priority_high;
			item_s1.priority_low  <= status.priority_low;
			item_s1.last          <= status.last;
		end
	end

	assign item_valid = valid_s1;
	assign item       = item_s1;

endmodule

FILE: src/ris_queue.sv
// Short queue that decouples the front stage from the selection back end.
// Depends on ris_pkg.
module ris_queue import ris_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push_valid,
	input  ris_item_t push_item,
	output logic      push_ready,
	output logic      pop_valid,
	output ris_item_t pop_item,
	input  logic      pop
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	ris_item_t        entries_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             do_pop;

	assign push_ready = count_q != CNT_W'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;
	assign pop_item   = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

FILE: src/ris_back.sv
// Back end: keeps the running best picks and decides the active reference at scan end.
// Depends on ris_pkg and ris_select_if.
module ris_back import ris_pkg::*; #(
	parameter int INPUT_COUNT = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  ris_cfg_t    cfg,
	input  logic        item_valid,
	input  ris_item_t   item,
	output logic        item_pop,
	ris_select_if.source selection
);

	logic signed [3:0] act_q;
	logic              chg_q;
	logic              out_valid_q;
	logic              best_found_q;
	logic [2:0]        best_ch_q;
	logic [15:0]       best_rank_q;
	logic [2:0]        comb_ch_q;
	logic [31:0]       comb_rank_q;
	logic              man_elig_q;

	logic              best_found_n;
	logic [2:0]        best_ch_n;
	logic [15:0]       best_rank_n;
	logic [2:0]        comb_ch_n;
	logic [31:0]       comb_rank_n;
	logic              man_elig_n;
	logic [31:0]       rank32;
	logic              is_act;
	logic signed [3:0] pick;
	logic signed [3:0] act_n;
	logic              manual_ok;

	// A non-final word never produces a result, so it may pass a stalled output.
	assign item_pop = item_valid && (!item.last || !out_valid_q || selection.ready);

	assign rank32    = {item.priority_high, item.priority_low};
	assign is_act    = !act_q[3] && (act_q[2:0] == item.channel);
	assign manual_ok = (cfg.select_method == METHOD_MANUAL) && !cfg.manual_channel[3] &&
		(32'(cfg.manual_channel[2:0]) < INPUT_COUNT);

	always_comb begin
		best_found_n = best_found_q;
		best_ch_n    = best_ch_q;
		best_rank_n  = best_rank_q;
		comb_ch_n    = comb_ch_q;
		comb_rank_n  = comb_rank_q;
		man_elig_n   = item.manual_hit ? item.elig : man_elig_q;
		if (item.elig) begin
			if (!best_found_q) begin
				best_found_n = 1'b1;
				best_ch_n    = item.channel;
				best_rank_n  = item.priority_high;
				comb_ch_n    = item.channel;
				comb_rank_n  = rank32;
			end else begin
				if (item.priority_high < best_rank_q ||
					(item.priority_high == best_rank_q && is_act)) begin
					best_ch_n   = item.channel;
					best_rank_n = item.priority_high;
				end
				if (rank32 < comb_rank_q || (rank32 == comb_rank_q && is_act)) begin
					comb_ch_n   = item.channel;
					comb_rank_n = rank32;
				end
			end
		end

		pick = best_found_n ? $signed({1'b0, best_ch_n}) : NO_CHANNEL;
		if (manual_ok && man_elig_n) begin
			pick = cfg.manual_channel;
		end
		act_n = act_q;
		if (pick != act_q) begin
			if (cfg.select_method == METHOD_SSM && best_found_n) begin
				act_n = $signed({1'b0, comb_ch_n});
			end else begin
				act_n = pick;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q        <= NO_CHANNEL;
			chg_q        <= 1'b0;
			out_valid_q  <= 1'b0;
			best_found_q <= 1'b0;
			man_elig_q   <= 1'b0;
		end else begin
			if (item_pop && item.last) begin
				out_valid_q <= 1'b1;
			end else if (selection.ready) begin
				out_valid_q <= 1'b0;
			end
			if (item_pop) begin
				if (item.last) begin
					act_q        <= act_n;
					chg_q        <= act_n != act_q;
					best_found_q <= 1'b0;
					man_elig_q   <= 1'b0;
				end else begin
					best_found_q <= best_found_n;
					man_elig_q   <= man_elig_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_pop && !item.last) begin
			best_ch_q   <= best_ch_n;
			best_rank_q <= best_rank_n;
			comb_ch_q   <= comb_ch_n;
			comb_rank_q <= comb_rank_n;
		end
	end

	assign selection.valid          = out_valid_q;
	assign selection.active_channel = act_q;
	assign selection.changed        = chg_q;

	a_result_follows_last: assert property (@(posedge clk) disable iff (!arst_n)
		item_pop && item.last |=> out_valid_q)
		else $error("no result after the final word of a scan");

	a_scan_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		item_pop && item.last |=> !best_found_q && !man_elig_q)
		else $error("scan state not cleared at scan end");

	a_changed_flag: assert property (@(posedge clk) disable iff (!arst_n)
		item_pop && item.last |=> chg_q == (act_q != $past(act_q)))
		else $error("changed flag disagrees with the active channel");

	a_active_only_at_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		!(item_pop && item.last) |=> $stable(act_q))
		else $error("active channel moved outside a scan end");

	a_negative_is_none: assert property (@(posedge clk) disable iff (!arst_n)
		act_q[3] |-> act_q == NO_CHANNEL)
		else $error("active channel holds an invalid negative code");

endmodule

FILE: src/reference_input_selector.sv
// Reference input selector top level: configuration registers and the three stages.
// Depends on ris_pkg, ris_status_if, ris_select_if, ris_front, ris_queue and ris_back.
//
// Usage: a scan is a run of status words on the status channel, one per reference
// input in ascending channel order, with last set on the final word. A word is taken
// when status.valid and status.ready are both high. After the final word the block
// offers one word on the selection channel: the active channel (-1 for none) and a
// flag that says whether it changed on this scan.
// Throughput is one status word per cycle while the queue has room. The selection word
// is registered: the final status word passes through the front register and the queue,
// and the back end's compare-and-hold sets the output register.
// When the receiver stalls, the result is held and non-final words of the next scan
// keep flowing; the final word of the next scan waits in the queue until the result
// is taken, and the status channel stalls once the queue fills.
// Reset clears the active channel to none, empties the pipeline and the queue, and
// sets select_method to priority mode and manual_channel to none.
// Configuration is written through the APB port at byte address 4*index.
module reference_input_selector import ris_pkg::*; #(
	parameter int INPUT_COUNT = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	ris_status_if.sink   status,
	ris_select_if.source selection,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	ris_cfg_t  cfg_q;
	logic      front_valid;
	ris_item_t front_item;
	logic      queue_ready;
	logic      queue_valid;
	ris_item_t queue_item;
	logic      back_pop;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.select_method  <= METHOD_PRIORITY;
			cfg_q.manual_channel <= NO_CHANNEL;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_SELECT_METHOD:  cfg_q.select_method  <= pwdata[1:0];
				REG_MANUAL_CHANNEL: cfg_q.manual_channel <= $signed(pwdata[3:0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_SELECT_METHOD: prdata = {30'd0, cfg_q.select_method};
			default:           prdata = {28'd0, cfg_q.manual_channel};
		endcase
	end

	ris_front #(.INPUT_COUNT(INPUT_COUNT)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.status     (status),
		.cfg        (cfg_q),
		.item_valid (front_valid),
		.item       (front_item),
		.item_ready (queue_ready)
	);

	ris_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_item  (front_item),
		.push_ready (queue_ready),
		.pop_valid  (queue_valid),
		.pop_item   (queue_item),
		.pop        (back_pop)
	);

	ris_back #(.INPUT_COUNT(INPUT_COUNT)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (queue_valid),
		.item       (queue_item),
		.item_pop   (back_pop),
		.selection  (selection)
	);

endmodule
